>>> hdl/fcr_pkg.sv
// Shared types and constants for the floppy controller register front end.
`timescale 1ns / 1ps

package fcr_pkg;

  // Default geometry
  localparam int DRIVE_COUNT_DEF       = 4;
  localparam int TRACK_COUNT_DEF       = 77;
  localparam int SECTORS_PER_TRACK_DEF = 26;

  // Fixed field widths
  localparam int DATA_W   = 8;
  localparam int DRIVE_W  = 2;
  localparam int INDEX_W  = 11;
  localparam int ADDR_W   = 16;
  localparam int MASK_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Bus operation codes
  typedef enum logic [1:0] {
    OP_ADDR_LO = 2'd0,
    OP_ADDR_HI = 2'd1,
    OP_COMMAND = 2'd2,
    OP_STATUS  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITABLE = 1'b1;

  // Command byte bit positions
  localparam int CMD_CLEAR   = 0;
  localparam int CMD_PULSE   = 1;
  localparam int CMD_DIR_IN  = 2;
  localparam int CMD_SELECT  = 3;
  localparam int CMD_DRV_LO  = 4;
  localparam int CMD_DRV_HI  = 5;
  localparam int CMD_RD      = 6;
  localparam int CMD_WR      = 7;

  // Status byte bit positions
  localparam int ST_INOP       = 0;
  localparam int ST_STEP_RDY   = 1;
  localparam int ST_TRACK0     = 2;
  localparam int ST_IO_DONE    = 3;
  localparam int ST_TRACK_FLT  = 4;
  localparam int ST_NOT_READY  = 7;

  // One result item
  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               start;
    logic               write;
    logic [DRIVE_W-1:0] drive;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  address;
  } result_t;

endpackage

>>> hdl/fcr_core.sv
// Controller state and per-access command, step, validate and status logic.
`timescale 1ns / 1ps

module fcr_core #(
  parameter int DRIVE_COUNT       = fcr_pkg::DRIVE_COUNT_DEF,
  parameter int TRACK_COUNT       = fcr_pkg::TRACK_COUNT_DEF,
  parameter int SECTORS_PER_TRACK = fcr_pkg::SECTORS_PER_TRACK_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  fcr_pkg::op_t                op,
  input  logic [fcr_pkg::DATA_W-1:0]  data,
  input  logic [fcr_pkg::DATA_W-1:0]  trk,
  input  logic [fcr_pkg::DATA_W-1:0]  sec,
  input  logic [fcr_pkg::MASK_W-1:0]  present_mask,
  input  logic [fcr_pkg::MASK_W-1:0]  writable_mask,
  output fcr_pkg::result_t            result
);

  localparam int TRACK_W = (TRACK_COUNT > 2) ? $clog2(TRACK_COUNT) : 1;
  localparam int PROD_W  = 2 * fcr_pkg::DATA_W + 1;

  // State
  logic [TRACK_W-1:0]          head_track [DRIVE_COUNT];
  logic [TRACK_W-1:0]          head_track_next [DRIVE_COUNT];
  logic [fcr_pkg::DRIVE_W-1:0] chosen_drive, chosen_drive_next;
  logic [fcr_pkg::ADDR_W-1:0]  buffer_base, buffer_base_next;
  logic last_step_bit, last_step_bit_next;
  logic track_fault, track_fault_next;
  logic io_done, io_done_next;
  logic head_off, head_off_next;
  logic inoperative, inoperative_next;

  // Combinational work variables
  logic [TRACK_W-1:0]          cur_trk;
  logic [TRACK_W-1:0]          new_trk;
  logic [fcr_pkg::DRIVE_W-1:0] drv;
  logic                        cur_valid;
  logic                        new_valid;
  logic                        new_ready;
  logic                        is_write;
  logic                        step_edge;
  logic [PROD_W-1:0]           lin_sector;

  // Track of the currently selected drive, for status
  always_comb begin
    cur_trk = '0;
    for (int i = 0; i < DRIVE_COUNT; i++) begin
      if (chosen_drive == fcr_pkg::DRIVE_W'(i)) begin
        cur_trk = head_track[i];
      end
    end
  end

  assign cur_valid = ({1'b0, chosen_drive} < 3'(DRIVE_COUNT));

  // Next state and result for one access
  always_comb begin
    head_track_next    = head_track;
    chosen_drive_next  = chosen_drive;
    buffer_base_next   = buffer_base;
    last_step_bit_next = last_step_bit;
    track_fault_next   = track_fault;
    io_done_next       = io_done;
    head_off_next      = head_off;
    inoperative_next   = inoperative;
    result             = '0;
    drv                = chosen_drive;
    new_trk            = '0;
    new_valid          = 1'b0;
    new_ready          = 1'b0;
    is_write           = 1'b0;
    step_edge          = 1'b0;
    lin_sector         = PROD_W'(trk) * PROD_W'(SECTORS_PER_TRACK) + PROD_W'(sec)
                         - PROD_W'(1);

    unique case (op)
      fcr_pkg::OP_ADDR_LO: begin
        buffer_base_next = {buffer_base[fcr_pkg::ADDR_W-1:fcr_pkg::DATA_W], data};
      end
      fcr_pkg::OP_ADDR_HI: begin
        buffer_base_next = {data, buffer_base[fcr_pkg::DATA_W-1:0]};
      end
      fcr_pkg::OP_STATUS: begin
        result.read_data[fcr_pkg::ST_STEP_RDY]  = 1'b1;
        result.read_data[fcr_pkg::ST_TRACK_FLT] = track_fault;
        result.read_data[fcr_pkg::ST_INOP]      = inoperative;
        result.read_data[fcr_pkg::ST_TRACK0]    = cur_valid && (cur_trk == '0);
        result.read_data[fcr_pkg::ST_IO_DONE]   = io_done;
        result.read_data[fcr_pkg::ST_NOT_READY] =
          head_off || !(cur_valid && present_mask[chosen_drive]);
      end
      fcr_pkg::OP_COMMAND: begin
        // Clear flags
        if (data[fcr_pkg::CMD_CLEAR]) begin
          inoperative_next = 1'b0;
          track_fault_next = 1'b0;
        end
        // Drive select; a change unloads the head
        if (data[fcr_pkg::CMD_SELECT]) begin
          drv = data[fcr_pkg::CMD_DRV_HI:fcr_pkg::CMD_DRV_LO];
          if (drv != chosen_drive) begin
            head_off_next = 1'b1;
          end
        end
        chosen_drive_next = drv;
        new_valid = ({1'b0, drv} < 3'(DRIVE_COUNT));
        new_ready = new_valid && present_mask[drv];
        for (int i = 0; i < DRIVE_COUNT; i++) begin
          if (drv == fcr_pkg::DRIVE_W'(i)) begin
            new_trk = head_track[i];
          end
        end
        // Step on a rising STEP edge, saturating at both ends
        step_edge = data[fcr_pkg::CMD_PULSE] && !last_step_bit;
        if (step_edge) begin
          io_done_next = 1'b0;
          if (data[fcr_pkg::CMD_DIR_IN]) begin
            if (new_trk < TRACK_W'(TRACK_COUNT - 1)) begin
              new_trk = new_trk + TRACK_W'(1);
            end
          end else if (new_trk != '0) begin
            new_trk = new_trk - TRACK_W'(1);
          end
          for (int i = 0; i < DRIVE_COUNT; i++) begin
            if (drv == fcr_pkg::DRIVE_W'(i)) begin
              head_track_next[i] = new_trk;
            end
          end
        end
        // Read or write validation, read first
        if (data[fcr_pkg::CMD_RD] || data[fcr_pkg::CMD_WR]) begin
          is_write         = !data[fcr_pkg::CMD_RD];
          io_done_next     = 1'b0;
          track_fault_next = 1'b0;
          inoperative_next = 1'b0;
          if (!new_ready || (is_write && !writable_mask[drv])) begin
            inoperative_next = 1'b1;
            head_off_next    = 1'b1;
          end else begin
            head_off_next = 1'b0;
            if (trk >= fcr_pkg::DATA_W'(TRACK_COUNT) ||
                trk != fcr_pkg::DATA_W'(new_trk)) begin
              track_fault_next = 1'b1;
              io_done_next     = 1'b1;
            end else if (sec == '0 ||
                         sec > fcr_pkg::DATA_W'(SECTORS_PER_TRACK)) begin
              head_off_next = 1'b1;
            end else begin
              io_done_next   = 1'b1;
              result.start   = 1'b1;
              result.write   = is_write;
              result.drive   = drv;
              result.index   = lin_sector[fcr_pkg::INDEX_W-1:0];
              result.address = buffer_base;
            end
          end
        end
        last_step_bit_next = data[fcr_pkg::CMD_PULSE];
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per executed access
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DRIVE_COUNT; i++) begin
        head_track[i] <= '0;
      end
      chosen_drive  <= '0;
      buffer_base   <= '0;
      last_step_bit <= 1'b0;
      track_fault   <= 1'b0;
      io_done       <= 1'b0;
      head_off      <= 1'b1;
      inoperative   <= 1'b0;
    end else if (fire) begin
      head_track    <= head_track_next;
      chosen_drive  <= chosen_drive_next;
      buffer_base   <= buffer_base_next;
      last_step_bit <= last_step_bit_next;
      track_fault   <= track_fault_next;
      io_done       <= io_done_next;
      head_off      <= head_off_next;
      inoperative   <= inoperative_next;
    end
  end

endmodule

>>> hdl/floppy_controller_registers_top.sv
// Top level: input register, configuration registers, core and output register.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------------
//   in      | in_valid / in_stall   | operation, bus_data, buffer_track, buffer_sector
//   out     | out_valid / out_stall | read_data, transfer_*, sector_index, buffer_address
//   cfg     | cfg_write (no wait)   | cfg_index, cfg_data
//
// One access per cycle while the output does not stall. An access taken into the input
// register executes as it leaves it, updating the core state and loading the output
// register, from which its result transfers out; back-to-back accesses see each other.
// Synchronous active-high reset clears all control state and the masks, but marks the head unloaded.
// A stall on the output holds both stages; in_stall is high only while the input
// register is full and the output register cannot move on.
`timescale 1ns / 1ps

module floppy_controller_registers_top #(
  parameter int DRIVE_COUNT       = fcr_pkg::DRIVE_COUNT_DEF,
  parameter int TRACK_COUNT       = fcr_pkg::TRACK_COUNT_DEF,
  parameter int SECTORS_PER_TRACK = fcr_pkg::SECTORS_PER_TRACK_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration
  input  logic                           cfg_write,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcr_pkg::MASK_W-1:0]     cfg_data,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     operation,
  input  logic [fcr_pkg::DATA_W-1:0]     bus_data,
  input  logic [fcr_pkg::DATA_W-1:0]     buffer_track,
  input  logic [fcr_pkg::DATA_W-1:0]     buffer_sector,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fcr_pkg::DATA_W-1:0]     read_data,
  output logic                           transfer_start,
  output logic                           transfer_write,
  output logic [fcr_pkg::DRIVE_W-1:0]    transfer_drive,
  output logic [fcr_pkg::INDEX_W-1:0]    sector_index,
  output logic [fcr_pkg::ADDR_W-1:0]     buffer_address
);

  logic [fcr_pkg::MASK_W-1:0] drive_present_mask;
  logic [fcr_pkg::MASK_W-1:0] drive_writable_mask;

  logic                       s1_valid;
  fcr_pkg::op_t               s1_op;
  logic [fcr_pkg::DATA_W-1:0] s1_data;
  logic [fcr_pkg::DATA_W-1:0] s1_trk;
  logic [fcr_pkg::DATA_W-1:0] s1_sec;

  logic             advance;
  logic             fire;
  fcr_pkg::result_t core_result;
  fcr_pkg::result_t out_reg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_present_mask  <= '0;
      drive_writable_mask <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fcr_pkg::CFG_PRESENT:  drive_present_mask  <= cfg_data;
        fcr_pkg::CFG_WRITABLE: drive_writable_mask <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= fcr_pkg::op_t'(operation);
      s1_data <= bus_data;
      s1_trk  <= buffer_track;
      s1_sec  <= buffer_sector;
    end
  end

  fcr_core #(
    .DRIVE_COUNT       (DRIVE_COUNT),
    .TRACK_COUNT       (TRACK_COUNT),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .op            (s1_op),
    .data          (s1_data),
    .trk           (s1_trk),
    .sec           (s1_sec),
    .present_mask  (drive_present_mask),
    .writable_mask (drive_writable_mask),
    .result        (core_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg <= core_result;
    end
  end

  assign read_data      = out_reg.read_data;
  assign transfer_start = out_reg.start;
  assign transfer_write = out_reg.write;
  assign transfer_drive = out_reg.drive;
  assign sector_index   = out_reg.index;
  assign buffer_address = out_reg.address;

endmodule

>>> tb/floppy_regs_checker.sv
// Checker for the floppy controller register front end: predicts and compares results.
`timescale 1ns / 1ps

module floppy_regs_checker #(
  parameter int DRIVE_COUNT       = fcr_pkg::DRIVE_COUNT_DEF,
  parameter int TRACK_COUNT       = fcr_pkg::TRACK_COUNT_DEF,
  parameter int SECTORS_PER_TRACK = fcr_pkg::SECTORS_PER_TRACK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcr_pkg::MASK_W-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [fcr_pkg::DATA_W-1:0]    bus_data,
  input  logic [fcr_pkg::DATA_W-1:0]    buffer_track,
  input  logic [fcr_pkg::DATA_W-1:0]    buffer_sector,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [fcr_pkg::DATA_W-1:0]    read_data,
  input  logic                          transfer_start,
  input  logic                          transfer_write,
  input  logic [fcr_pkg::DRIVE_W-1:0]   transfer_drive,
  input  logic [fcr_pkg::INDEX_W-1:0]   sector_index,
  input  logic [fcr_pkg::ADDR_W-1:0]    buffer_address,
  output int                            mismatch_count,
  output int                            outstanding
);
  import fcr_pkg::*;

  // Modeled controller state
  logic [6:0]        trk_pos [4];
  logic [DRIVE_W-1:0] cur_drive;
  logic [ADDR_W-1:0] base_addr;
  logic              step_level;
  logic              fault_flag;
  logic              done_flag;
  logic              unloaded;
  logic              inop_flag;
  logic [MASK_W-1:0] present_mask;
  logic [MASK_W-1:0] writable_mask;

  result_t           pending_results [$];
  int                mismatches;

  function automatic logic drive_exists();
    return int'(cur_drive) < DRIVE_COUNT;
  endfunction

  function automatic logic drive_usable();
    return drive_exists() && present_mask[cur_drive];
  endfunction

  // Apply one bus access to the modeled state and return the result it produces
  function automatic result_t predict_access(input op_t op, input logic [7:0] data,
                                             input logic [7:0] trk, input logic [7:0] sec);
    result_t r;
    logic    is_wr;
    int      lin;
    r = '0;
    case (op)
      OP_ADDR_LO: base_addr[7:0] = data;
      OP_ADDR_HI: base_addr[15:8] = data;
      OP_STATUS: begin
        r.read_data[ST_STEP_RDY]  = 1'b1;
        r.read_data[ST_TRACK_FLT] = fault_flag;
        r.read_data[ST_INOP]      = inop_flag;
        r.read_data[ST_TRACK0]    = drive_exists() && trk_pos[cur_drive] == 7'd0;
        r.read_data[ST_IO_DONE]   = done_flag;
        r.read_data[ST_NOT_READY] = unloaded || !drive_usable();
      end
      default: begin
        if (data[CMD_CLEAR]) begin
          inop_flag  = 1'b0;
          fault_flag = 1'b0;
        end
        // drive select; a new drive unloads the head
        if (data[CMD_SELECT]) begin
          if (data[CMD_DRV_HI:CMD_DRV_LO] != cur_drive) unloaded = 1'b1;
          cur_drive = data[CMD_DRV_HI:CMD_DRV_LO];
        end
        // head step on a rising STEP, saturating at both ends
        if (data[CMD_PULSE] && !step_level) begin
          done_flag = 1'b0;
          if (drive_exists()) begin
            if (data[CMD_DIR_IN]) begin
              if (int'(trk_pos[cur_drive]) < TRACK_COUNT - 1)
                trk_pos[cur_drive] = trk_pos[cur_drive] + 7'd1;
            end else if (trk_pos[cur_drive] != 7'd0) begin
              trk_pos[cur_drive] = trk_pos[cur_drive] - 7'd1;
            end
          end
        end
        // transfer validation, read wins over write
        if (data[CMD_RD] || data[CMD_WR]) begin
          is_wr      = !data[CMD_RD];
          done_flag  = 1'b0;
          fault_flag = 1'b0;
          inop_flag  = 1'b0;
          if (!drive_usable() || (is_wr && !writable_mask[cur_drive])) begin
            inop_flag = 1'b1;
            unloaded  = 1'b1;
          end else begin
            unloaded = 1'b0;
            if (int'(trk) >= TRACK_COUNT || trk != {1'b0, trk_pos[cur_drive]}) begin
              fault_flag = 1'b1;
              done_flag  = 1'b1;
            end else if (sec == 8'd0 || int'(sec) > SECTORS_PER_TRACK) begin
              unloaded = 1'b1;
            end else begin
              done_flag = 1'b1;
              lin       = int'(trk) * SECTORS_PER_TRACK + int'(sec) - 1;
              r.start   = 1'b1;
              r.write   = is_wr;
              r.drive   = cur_drive;
              r.index   = lin[INDEX_W-1:0];
              r.address = base_addr;
            end
          end
        end
        step_level = data[CMD_PULSE];
      end
    endcase
    return r;
  endfunction

  // Track configuration, predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) trk_pos[i] = '0;
      cur_drive     = '0;
      base_addr     = '0;
      step_level    = 1'b0;
      fault_flag    = 1'b0;
      done_flag     = 1'b0;
      unloaded      = 1'b1;
      inop_flag     = 1'b0;
      present_mask  = '0;
      writable_mask = '0;
      mismatches    = 0;
      pending_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PRESENT:  present_mask  = cfg_data;
          CFG_WRITABLE: writable_mask = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {read_data, transfer_start, transfer_write, transfer_drive,
               sector_index, buffer_address};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: %s rd=%02h start=%0b wr=%0b",
                     $time, "actual", got.read_data, got.start, got.write,
                     " drv=%0d idx=%0d addr=%04h", got.drive, got.index, got.address);
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data || got.start !== want.start ||
              got.write !== want.write || got.drive !== want.drive ||
              got.index !== want.index || got.address !== want.address) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected rd=%02h start=%0b wr=%0b",
                       $time, want.read_data, want.start, want.write,
                       " drv=%0d idx=%0d addr=%04h", want.drive, want.index,
                       want.address);
              $display("%0t:           actual   rd=%02h start=%0b wr=%0b",
                       $time, got.read_data, got.start, got.write,
                       " drv=%0d idx=%0d addr=%04h", got.drive, got.index,
                       got.address);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(predict_access(op_t'(operation), bus_data, buffer_track,
                                                 buffer_sector));
    end
    mismatch_count <= mismatches;
    outstanding    <= pending_results.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the floppy controller register testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import fcr_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MASK_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           operation;
  logic [DATA_W-1:0]    bus_data;
  logic [DATA_W-1:0]    buffer_track;
  logic [DATA_W-1:0]    buffer_sector;
  logic                 out_valid;
  logic                 out_stall;
  logic [DATA_W-1:0]    read_data;
  logic                 transfer_start;
  logic                 transfer_write;
  logic [DRIVE_W-1:0]   transfer_drive;
  logic [INDEX_W-1:0]   sector_index;
  logic [ADDR_W-1:0]    buffer_address;

  int                   fail_count;
  int                   outstanding;
  logic                 calm;

  // Rough head position per drive, only to aim transfers at the right track
  logic [6:0]           pos [4];
  logic [1:0]           drv_now;
  logic                 step_was;

  floppy_controller_registers_top dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .operation, .bus_data, .buffer_track, .buffer_sector,
    .out_valid, .out_stall, .read_data, .transfer_start, .transfer_write,
    .transfer_drive, .sector_index, .buffer_address
  );

  floppy_regs_checker checker_i (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .operation, .bus_data, .buffer_track, .buffer_sector,
    .out_valid, .out_stall, .read_data, .transfer_start, .transfer_write,
    .transfer_drive, .sector_index, .buffer_address,
    .mismatch_count(fail_count), .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls in random bursts, none once the run goes calm
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Watchdog: too long without any transfer on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Follow head movement the way the controller does
  function automatic void track_command(input logic [7:0] data);
    if (data[CMD_SELECT]) drv_now = data[CMD_DRV_HI:CMD_DRV_LO];
    if (data[CMD_PULSE] && !step_was) begin
      if (data[CMD_DIR_IN]) begin
        if (int'(pos[drv_now]) < TRACK_COUNT_DEF - 1) pos[drv_now] = pos[drv_now] + 7'd1;
      end else if (pos[drv_now] != 7'd0) begin
        pos[drv_now] = pos[drv_now] - 7'd1;
      end
    end
    step_was = data[CMD_PULSE];
  endfunction

  // One input transfer, with an optional gap before it
  task automatic send_access(input op_t op, input logic [7:0] data, input logic [7:0] trk,
                             input logic [7:0] sec);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    bus_data      <= data;
    buffer_track  <= trk;
    buffer_sector <= sec;
    if (op == OP_COMMAND) track_command(data);
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every pending result is out and the pipe is empty
  task automatic drain_and_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_masks(input logic [3:0] present, input logic [3:0] writable);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRESENT;
    cfg_data  <= present;
    @(posedge clk);
    cfg_index <= CFG_WRITABLE;
    cfg_data  <= writable;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed commands aimed at the head track, plus noise
  task automatic random_access();
    int         kind;
    logic [7:0] d;
    logic [7:0] t;
    logic [7:0] s;
    logic [1:0] tgt;
    kind = $urandom_range(0, 99);
    d    = 8'($urandom);
    t    = 8'($urandom);
    s    = 8'($urandom);
    if (kind < 8) begin
      send_access(OP_ADDR_LO, d, t, s);
    end else if (kind < 16) begin
      send_access(OP_ADDR_HI, d, t, s);
    end else if (kind < 30) begin
      send_access(OP_STATUS, d, t, s);
    end else if (kind < 40) begin
      send_access(OP_COMMAND, d, t, s);
    end else begin
      d = 8'h00;
      d[CMD_CLEAR] = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        d[CMD_SELECT]            = 1'b1;
        d[CMD_DRV_HI:CMD_DRV_LO] = 2'($urandom_range(0, 3));
      end
      tgt = d[CMD_SELECT] ? d[CMD_DRV_HI:CMD_DRV_LO] : drv_now;
      if ($urandom_range(0, 1) == 0) begin
        // head movement, mostly inward
        d[CMD_PULSE]  = !step_was;
        d[CMD_DIR_IN] = ($urandom_range(0, 4) != 0);
      end else begin
        // transfer; STEP held so the head stays put
        d[CMD_PULSE] = step_was;
        case ($urandom_range(0, 3))
          0:       d[CMD_RD] = 1'b1;
          1, 2:    d[CMD_WR] = 1'b1;
          default: begin
            d[CMD_RD] = 1'b1;
            d[CMD_WR] = 1'b1;
          end
        endcase
        if ($urandom_range(0, 6) != 0) t = {1'b0, pos[tgt]};
        case ($urandom_range(0, 7))
          0:       s = 8'd0;
          1:       s = 8'd27;
          2:       ;
          default: s = 8'($urandom_range(1, 26));
        endcase
      end
      send_access(OP_COMMAND, d, t, s);
    end
  endtask

  // Long run of STEP pulses to drive the head into a stop, then use it
  task automatic sweep_head(input logic inward);
    logic [7:0] d;
    d = 8'h00;
    d[CMD_SELECT]            = 1'b1;
    d[CMD_DRV_HI:CMD_DRV_LO] = 2'($urandom_range(0, 3));
    send_access(OP_COMMAND, d, 8'($urandom), 8'($urandom));
    for (int k = 0; k < 160; k++) begin
      d = 8'h00;
      d[CMD_DIR_IN] = inward;
      d[CMD_PULSE]  = (k % 2 == 0);
      send_access(OP_COMMAND, d, 8'($urandom), 8'($urandom));
    end
    d = 8'h00;
    d[CMD_RD] = 1'b1;
    send_access(OP_COMMAND, d, {1'b0, pos[drv_now]}, 8'($urandom_range(1, 26)));
    send_access(OP_STATUS, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [3:0] present_set [6];
    logic [3:0] writable_set [6];
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= CFG_PRESENT;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    operation     <= OP_STATUS;
    bus_data      <= '0;
    buffer_track  <= '0;
    buffer_sector <= '0;
    calm     = 1'b0;
    drv_now  = 2'd0;
    step_was = 1'b0;
    for (int i = 0; i < 4; i++) pos[i] = 7'd0;
    present_set  = '{4'h0, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0};
    writable_set = '{4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0};
    for (int p = 4; p < 6; p++) begin
      present_set[p]  = 4'($urandom_range(0, 15));
      writable_set[p] = 4'($urandom_range(0, 15));
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: drive 2 absent, drive 1 and 3 read-only
    write_masks(4'b1011, 4'b0101);
    send_access(OP_STATUS, 8'h00, 8'($urandom), 8'($urandom));
    send_access(OP_ADDR_LO, 8'hFF, 8'($urandom), 8'($urandom));
    send_access(OP_ADDR_HI, 8'h00, 8'($urandom), 8'($urandom));
    send_access(OP_ADDR_LO, 8'h00, 8'($urandom), 8'($urandom));
    send_access(OP_ADDR_HI, 8'hFF, 8'($urandom), 8'($urandom));
    send_access(OP_ADDR_LO, 8'h5A, 8'($urandom), 8'($urandom));
    send_access(OP_COMMAND, 8'h48, 8'd0, 8'd1);      // select 0 and read, first sector
    send_access(OP_COMMAND, 8'h80, 8'd0, 8'd26);     // write, last sector
    send_access(OP_COMMAND, 8'h40, 8'd0, 8'd0);      // sector zero
    send_access(OP_COMMAND, 8'h40, 8'd0, 8'd27);     // sector past the track
    send_access(OP_STATUS, 8'hFF, 8'hFF, 8'hFF);
    send_access(OP_COMMAND, 8'h40, 8'd1, 8'd5);      // head not on that track
    send_access(OP_COMMAND, 8'h40, 8'd255, 8'd5);    // track beyond the disk
    send_access(OP_STATUS, 8'h00, 8'h00, 8'h00);
    send_access(OP_COMMAND, 8'h01, 8'd0, 8'd0);      // clear flags
    send_access(OP_STATUS, 8'h00, 8'h00, 8'h00);
    send_access(OP_COMMAND, 8'h02, 8'd0, 8'd0);      // step out at track 0
    send_access(OP_COMMAND, 8'h06, 8'd0, 8'd0);      // STEP held, no edge
    send_access(OP_COMMAND, 8'h04, 8'd0, 8'd0);
    send_access(OP_COMMAND, 8'h06, 8'd0, 8'd0);      // step in to track 1
    send_access(OP_COMMAND, 8'hC0, 8'd1, 8'd13);     // read and write together
    send_access(OP_COMMAND, 8'h98, 8'd0, 8'd1);      // write to read-only drive
    send_access(OP_COMMAND, 8'h68, 8'd0, 8'd1);      // read from absent drive
    send_access(OP_STATUS, 8'h00, 8'h00, 8'h00);
    send_access(OP_COMMAND, 8'h78, 8'd0, 8'd26);     // select 3, read
    drain_and_idle();

    // Random phases over several mask settings
    for (int p = 0; p < 6; p++) begin
      if (p == 5) calm = 1'b1;
      write_masks(present_set[p], writable_set[p]);
      if (p == 1) sweep_head(1'b1);
      for (int n = 0; n < 130; n++) begin
        random_access();
        if ($urandom_range(0, 99) == 0) drain_and_idle();
      end
      if (p == 4) sweep_head(1'b0);
      drain_and_idle();
    end

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> floppy_controller_registers_top.f
hdl/fcr_pkg.sv
hdl/fcr_core.sv
hdl/floppy_controller_registers_top.sv
tb/floppy_regs_checker.sv
tb/testbench.sv
